/* sv/mbrf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrf_pkg
// Types, codes and constants of the MBR FAT32 partition finder.
// ----------------------------------------------------------------------------
package mbrf_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SECT0 = 2'd1,
    PH_PART  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_FOUND = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  // Input command codes. Code 3 is unused and ignored.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_FAIL  = 2'd2;

  localparam int unsigned PosW       = 9;
  localparam int unsigned LbaW       = 32;
  localparam int unsigned NumEntries = 4;

  localparam logic [PosW-1:0] POS_LAST      = 9'd511;
  localparam logic [PosW-1:0] POS_SIG_LO    = 9'd510;
  localparam logic [PosW-1:0] POS_SIG_HI    = 9'd511;
  localparam logic [PosW-1:0] POS_TABLE     = 9'd446;
  localparam logic [PosW-1:0] POS_NAME      = 9'd82;
  localparam logic [PosW-1:0] POS_NAME_END  = 9'd86;
  localparam logic [PosW-1:0] POS_BPS       = 9'd11;
  localparam logic [PosW-1:0] POS_SPF16     = 9'd22;
  localparam logic [PosW-1:0] POS_SPF32     = 9'd36;
  localparam logic [PosW-1:0] POS_SPF32_END = 9'd39;

  localparam logic [7:0]  SIG_LO_BYTE  = 8'h55;
  localparam logic [7:0]  SIG_HI_BYTE  = 8'hAA;
  localparam logic [7:0]  TYPE_FAT32   = 8'h0B;
  localparam logic [7:0]  TYPE_FAT32_L = 8'h0C;
  localparam logic [15:0] SECTOR_BYTES = 16'd512;

  // Expected byte of the "FAT32" file system name.
  function automatic logic [7:0] fat_name_byte(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h46;
      3'd1:    ch = 8'h41;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h33;
      3'd4:    ch = 8'h32;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

/* sv/mbr_fat32_partition_finder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_fat32_partition_finder
// Walks the MBR of a disk and locates the first FAT32 volume.
// ----------------------------------------------------------------------------
// A start item makes the block request sector 0; the sector's 512 bytes then
// arrive as one item each, and a failure item reports a read that went wrong.
// Results are sector requests and a final found / not found verdict with the
// volume offset. No item holds up the input: each byte updates a few
// state registers, and any result goes into a registered output stage backed
// by a one-item skid buffer, so s_tready only drops when both are full.
module mbr_fat32_partition_finder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] lba
  output logic [1:0]       m_tuser    // [1:0] kind
);
  import mbrf_pkg::*;

  phase_t                 phase, phase_next;
  logic [PosW-1:0]        pos, pos_next;
  logic [1:0]             cur_entry, cur_entry_next;
  logic [LbaW-1:0]        cur_lba, cur_lba_next;
  logic [NumEntries-1:0]  entry_fat, entry_fat_next;
  logic [LbaW-1:0]        entry_lba [NumEntries];
  logic                   s0_boot, s0_boot_next;
  logic [1:0]             sig_ok, sig_ok_next;
  logic                   name_match, name_match_next;
  logic [15:0]            bps, bps_next;
  logic [15:0]            spf16, spf16_next;
  logic                   spf32_nz, spf32_nz_next;

  logic                   accept;
  logic                   emit;
  kind_t                  emit_kind;
  logic [LbaW-1:0]        emit_lba;
  logic [1:0]             op;
  logic [7:0]             b;

  logic                   sk_valid;
  kind_t                  sk_kind;
  logic [LbaW-1:0]        sk_lba;
  kind_t                  out_kind;

  // Partition table decode.
  logic [PosW-1:0]        rel;
  logic                   in_table;
  logic [1:0]             tab_e;
  logic [3:0]             tab_off;
  logic                   lba_wr;

  assign op       = s_tuser;
  assign b        = s_tdata;
  assign s_tready = !sk_valid;
  assign accept   = s_tvalid && s_tready;

  assign rel      = pos - POS_TABLE;
  assign in_table = (phase == PH_SECT0) && (pos >= POS_TABLE) && (pos < POS_SIG_LO);
  assign tab_e    = rel[5:4];
  assign tab_off  = rel[3:0];
  assign lba_wr   = accept && (op == OP_BYTE) && in_table && (tab_off[3:2] == 2'b10);

  always_comb begin
    logic            boot;
    logic [2:0]      first;
    logic            cand_ok;
    logic [1:0]      cand_idx;
    logic            do_cand;
    logic            s0_for_cand;

    phase_next      = phase;
    pos_next        = pos;
    cur_entry_next  = cur_entry;
    cur_lba_next    = cur_lba;
    entry_fat_next  = entry_fat;
    s0_boot_next    = s0_boot;
    sig_ok_next     = sig_ok;
    name_match_next = name_match;
    bps_next        = bps;
    spf16_next      = spf16;
    spf32_nz_next   = spf32_nz;
    emit            = 1'b0;
    emit_kind       = KIND_REQ;
    emit_lba        = '0;
    boot            = 1'b0;
    first           = 3'd0;
    do_cand         = 1'b0;
    s0_for_cand     = s0_boot;
    cand_ok         = 1'b0;
    cand_idx        = 2'd0;

    if (accept) begin
      if (op == OP_START) begin
        phase_next     = PH_SECT0;
        pos_next       = '0;
        cur_entry_next = '0;
        s0_boot_next   = 1'b0;
        emit           = 1'b1;
        emit_kind      = KIND_REQ;
        emit_lba       = '0;
      end else if (op == OP_FAIL && phase != PH_IDLE) begin
        if (phase == PH_SECT0) begin
          phase_next = PH_IDLE;
          pos_next   = '0;
          emit       = 1'b1;
          emit_kind  = KIND_NONE;
        end else begin
          do_cand = 1'b1;
          first   = {1'b0, cur_entry} + 3'd1;
        end
      end else if (op == OP_BYTE && phase != PH_IDLE) begin
        // Byte 0 opens a new sector and clears the boot record checks.
        if (pos == '0) begin
          sig_ok_next     = 2'b00;
          name_match_next = 1'b1;
          bps_next        = '0;
          spf16_next      = '0;
          spf32_nz_next   = 1'b0;
          if (phase == PH_SECT0) entry_fat_next = '0;
        end
        if (pos >= POS_NAME && pos <= POS_NAME_END &&
            b != fat_name_byte(3'(pos - POS_NAME))) name_match_next = 1'b0;
        if (pos == POS_BPS)            bps_next[7:0]    = b;
        if (pos == POS_BPS + 9'd1)     bps_next[15:8]   = b;
        if (pos == POS_SPF16)          spf16_next[7:0]  = b;
        if (pos == POS_SPF16 + 9'd1)   spf16_next[15:8] = b;
        if (pos >= POS_SPF32 && pos <= POS_SPF32_END && b != 8'd0) spf32_nz_next = 1'b1;
        if (pos == POS_SIG_LO && b == SIG_LO_BYTE) sig_ok_next[0] = 1'b1;
        if (pos == POS_SIG_HI && b == SIG_HI_BYTE) sig_ok_next[1] = 1'b1;
        if (in_table && tab_off == 4'd4)
          entry_fat_next[tab_e] = (b == TYPE_FAT32) || (b == TYPE_FAT32_L);

        if (pos != POS_LAST) begin
          pos_next = pos + 9'd1;
        end else begin
          pos_next = '0;
          boot = (sig_ok_next == 2'b11) &&
                 (name_match || (bps == SECTOR_BYTES && spf16 == '0 && spf32_nz));
          if (phase == PH_SECT0) begin
            if (sig_ok_next != 2'b11) begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              emit_kind  = KIND_NONE;
            end else begin
              s0_boot_next = boot;
              s0_for_cand  = boot;
              do_cand      = 1'b1;
              first        = 3'd0;
            end
          end else if (boot) begin
            phase_next = PH_IDLE;
            emit       = 1'b1;
            emit_kind  = KIND_FOUND;
            emit_lba   = cur_lba;
          end else begin
            do_cand = 1'b1;
            first   = {1'b0, cur_entry} + 3'd1;
          end
        end
      end
    end

    // Lowest FAT32-typed entry at or after the first index wins.
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (entry_fat_next[i] && (3'(i) >= first)) begin
        cand_ok  = 1'b1;
        cand_idx = 2'(i);
      end
    end

    if (do_cand) begin
      pos_next = '0;
      emit     = 1'b1;
      if (cand_ok) begin
        cur_entry_next = cand_idx;
        cur_lba_next   = entry_lba[cand_idx];
        phase_next     = PH_PART;
        emit_kind      = KIND_REQ;
        emit_lba       = entry_lba[cand_idx];
      end else begin
        phase_next = PH_IDLE;
        emit_kind  = s0_for_cand ? KIND_FOUND : KIND_NONE;
        emit_lba   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      pos        <= '0;
      cur_entry  <= '0;
      entry_fat  <= '0;
      s0_boot    <= 1'b0;
      sig_ok     <= 2'b00;
      name_match <= 1'b0;
      bps        <= '0;
      spf16      <= '0;
      spf32_nz   <= 1'b0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      cur_entry  <= cur_entry_next;
      entry_fat  <= entry_fat_next;
      s0_boot    <= s0_boot_next;
      sig_ok     <= sig_ok_next;
      name_match <= name_match_next;
      bps        <= bps_next;
      spf16      <= spf16_next;
      spf32_nz   <= spf32_nz_next;
    end
  end

  // Start LBAs and the LBA of the sector being read carry no reset.
  always_ff @(posedge clk) begin
    cur_lba <= cur_lba_next;
    if (lba_wr) entry_lba[tab_e][tab_off[1:0]*8 +: 8] <= b;
  end

  // Output register with a one-item skid buffer behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sk_valid <= 1'b0;
    end else begin
      if (sk_valid) begin
        if (m_tready) begin
          sk_valid <= 1'b0;
        end
      end else if (emit) begin
        if (m_tvalid && !m_tready) begin
          sk_valid <= 1'b1;
        end else begin
          m_tvalid <= 1'b1;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (m_tready) begin
        out_kind <= sk_kind;
        m_tdata  <= sk_lba;
      end
    end else if (emit) begin
      if (m_tvalid && !m_tready) begin
        sk_kind <= emit_kind;
        sk_lba  <= emit_lba;
      end else begin
        out_kind <= emit_kind;
        m_tdata  <= emit_lba;
      end
    end
  end

  assign m_tuser = out_kind;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> m_tvalid)
    else $error("skid buffer holds an item while the output stage is empty");

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (pos == '0))
    else $error("byte position not cleared while idle");

  a_part_entry_typed: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PART) |-> entry_fat[cur_entry])
    else $error("reading a partition whose type is not FAT32");

  a_none_lba_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_kind == KIND_NONE) |-> (m_tdata == '0))
    else $error("not-found result carries a nonzero offset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && emit) |=> sk_valid)
    else $error("result lost while the output stage was stalled");

endmodule
`default_nettype wire
